/* rtl/polar_decompose_3x3_defines.svh */
// Assertion macros for the polar decomposition block
`ifndef POLAR_DECOMPOSE_3X3_DEFINES_SVH
`define POLAR_DECOMPOSE_3X3_DEFINES_SVH
`ifndef SYNTHESIS
`define PD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* rtl/pd3_pkg.sv */
// Shared types, codes and arithmetic helpers for the polar decomposition block
`timescale 1ns / 1ps
`default_nettype none
package pd3_pkg;
    localparam int QW = 32;
    localparam logic signed [63:0] QMAX = 64'sd2147483647;
    localparam logic signed [63:0] QMIN = -64'sd2147483648;
    localparam logic signed [31:0] QHALF = 32'sd8388608;

    typedef logic signed [QW-1:0] q_t;

    typedef enum logic [1:0] {
        ST_CONV  = 2'd0,
        ST_ZDET  = 2'd1,
        ST_LIMIT = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_TOL  = 1'b0,
        REG_ITER = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_NORM0, S_CROSS, S_DET, S_CNORM, S_RMUL, S_DIV1, S_SQ1, S_DIV2,
        S_SQ2, S_G1, S_GD, S_DIV3, S_UPD, S_ENORM, S_TOL, S_CHECK, S_STR,
        S_SYM, S_OUT
    } state_t;

    typedef struct packed {
        logic   start;
        logic   busy;
    } lane_ctl_t;

    function automatic q_t sat32(input logic signed [63:0] v);
        if (v > QMAX) return q_t'(QMAX);
        if (v < QMIN) return q_t'(QMIN);
        return q_t'(v);
    endfunction

    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd8388608;
        return sat32(p >>> 24);
    endfunction

    function automatic logic signed [33:0] qabs(input q_t a);
        return (a < 0) ? -34'(a) : 34'(a);
    endfunction
endpackage
`default_nettype wire

/* rtl/pd3_lane.sv */
// One lane: cross product row, update and stretch product for one matrix row
`timescale 1ns / 1ps
`default_nettype none
module pd3_lane (
    input  wire logic         aclk,
    input  wire logic [2:0]   op,
    input  wire pd3_pkg::q_t  a0, a1, a2,
    input  wire pd3_pkg::q_t  b0, b1, b2,
    input  wire pd3_pkg::q_t  k1, k2,
    output pd3_pkg::q_t       r0, r1, r2,
    output pd3_pkg::q_t       e0, e1, e2
);
    import pd3_pkg::*;
    q_t r0_reg, r1_reg, r2_reg, e0_reg, e1_reg, e2_reg;
    q_t r0_next, r1_next, r2_next, e0_next, e1_next, e2_next;

    // op 0: cross(a,b); op 1: k1*a + k2*b, e = a - result; op 2: dot product
    always_comb begin
        r0_next = r0_reg; r1_next = r1_reg; r2_next = r2_reg;
        e0_next = e0_reg; e1_next = e1_reg; e2_next = e2_reg;
        case (op)
            3'd0: begin
                r0_next = sat32(64'(qmul(a1, b2)) - 64'(qmul(a2, b1)));
                r1_next = sat32(64'(qmul(a2, b0)) - 64'(qmul(a0, b2)));
                r2_next = sat32(64'(qmul(a0, b1)) - 64'(qmul(a1, b0)));
            end
            3'd1: begin
                r0_next = sat32(64'(qmul(k1, a0)) + 64'(qmul(k2, b0)));
                r1_next = sat32(64'(qmul(k1, a1)) + 64'(qmul(k2, b1)));
                r2_next = sat32(64'(qmul(k1, a2)) + 64'(qmul(k2, b2)));
                e0_next = sat32(64'(a0) - 64'(r0_next));
                e1_next = sat32(64'(a1) - 64'(r1_next));
                e2_next = sat32(64'(a2) - 64'(r2_next));
            end
            3'd2: begin
                r0_next = sat32(64'(qmul(a0, b0)) + 64'(qmul(a1, b1))
                                + 64'(qmul(a2, b2)));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        r0_reg <= r0_next; r1_reg <= r1_next; r2_reg <= r2_next;
        e0_reg <= e0_next; e1_reg <= e1_next; e2_reg <= e2_next;
    end

    assign r0 = r0_reg; assign r1 = r1_reg; assign r2 = r2_reg;
    assign e0 = e0_reg; assign e1 = e1_reg; assign e2 = e2_reg;
endmodule
`default_nettype wire

/* rtl/pd3_divsqrt.sv */
// Shared iterative unit: Q8.24 quotient and Q8.24 square root, one bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module pd3_divsqrt (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic               is_sqrt,
    input  wire pd3_pkg::q_t        num,
    input  wire logic signed [33:0] den,
    output logic                    done,
    output pd3_pkg::q_t             res
);
    import pd3_pkg::*;
    logic        busy_reg, busy_next, sq_reg, sq_next, neg_reg, neg_next;
    logic        spec_reg, spec_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next, quo_reg, quo_next, dv_reg, dv_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] t;
    logic [63:0] qv;

    always_comb begin
        busy_next = busy_reg; sq_next = sq_reg; neg_next = neg_reg;
        spec_next = spec_reg; cnt_next = cnt_reg; rem_next = rem_reg;
        quo_next = quo_reg; dv_next = dv_reg; bit_next = bit_reg;
        done_next = 1'b0; t = '0;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1; sq_next = is_sqrt; cnt_next = 6'd0;
                quo_next = '0; bit_next = 64'd1 << 62;
                if (is_sqrt) begin
                    spec_next = (num <= 0);
                    rem_next = (num <= 0) ? 64'd0 : (64'(num) << 24);
                    neg_next = 1'b0; dv_next = '0;
                end else begin
                    spec_next = (den == 0);
                    neg_next = (num < 0) ^ (den < 0);
                    rem_next = 64'(qabs(num)) << 24;
                    dv_next = 64'((den < 0) ? -den : den);
                end
            end
        end else begin
            cnt_next = cnt_reg + 6'd1;
            if (sq_reg) begin
                t = quo_reg + bit_reg;
                if (rem_reg >= t) begin
                    rem_next = rem_reg - t;
                    quo_next = (quo_reg >> 1) + bit_reg;
                end else begin
                    quo_next = quo_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg == 6'd31) begin busy_next = 1'b0; done_next = 1'b1; end
            end else begin
                // restoring division on 58-bit dividend, one quotient bit per cycle
                if ((rem_reg >> (6'd57 - cnt_reg)) >= dv_reg) begin
                    rem_next = rem_reg - (dv_reg << (6'd57 - cnt_reg));
                    quo_next = quo_reg | (64'd1 << (6'd57 - cnt_reg));
                end
                if (cnt_reg == 6'd57) begin busy_next = 1'b0; done_next = 1'b1; end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
        sq_reg <= sq_next; neg_reg <= neg_next; spec_reg <= spec_next;
        cnt_reg <= cnt_next; rem_reg <= rem_next; quo_reg <= quo_next;
        dv_reg <= dv_next; bit_reg <= bit_next;
    end

    assign done = done_reg;

    always_comb begin
        qv = quo_reg;
        if (sq_reg) res = spec_reg ? q_t'(0) : q_t'(quo_reg);
        else if (spec_reg) res = neg_reg ? q_t'(QMIN) : q_t'(QMAX);
        else res = neg_reg ? sat32(-$signed(qv)) :
                   ((qv > 64'(QMAX)) ? q_t'(QMAX) : q_t'(qv));
    end
endmodule
`default_nettype wire

/* rtl/pd3_merge.sv */
// Merge stage: column and row norms of a 3x3 matrix
`timescale 1ns / 1ps
`default_nettype none
module pd3_merge (
    input  wire logic        aclk,
    input  wire pd3_pkg::q_t m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output pd3_pkg::q_t      ncol,
    output pd3_pkg::q_t      nrow
);
    import pd3_pkg::*;
    q_t ncol_reg, nrow_reg, ncol_next, nrow_next;
    q_t c0, c1, c2, w0, w1, w2;

    function automatic q_t s3(input q_t a, input q_t b, input q_t c);
        return sat32(64'(qabs(a)) + 64'(qabs(b)) + 64'(qabs(c)));
    endfunction

    function automatic q_t mx(input q_t a, input q_t b, input q_t c);
        q_t m;
        m = 0;
        if (a > m) m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return m;
    endfunction

    always_comb begin
        c0 = s3(m00, m10, m20); c1 = s3(m01, m11, m21); c2 = s3(m02, m12, m22);
        w0 = s3(m00, m01, m02); w1 = s3(m10, m11, m12); w2 = s3(m20, m21, m22);
        ncol_next = mx(c0, c1, c2);
        nrow_next = mx(w0, w1, w2);
    end

    always_ff @(posedge aclk) begin
        ncol_reg <= ncol_next;
        nrow_reg <= nrow_next;
    end

    assign ncol = ncol_reg;
    assign nrow = nrow_reg;
endmodule
`default_nettype wire

/* rtl/polar_decompose_3x3.sv */
// Top level: polar decomposition of a 3x3 Q8.24 matrix by scaled Newton iteration
//
//  channel | direction | contents
//  s_      | in        | tdata: mode, a00..a22 ; one word per matrix
//  m_      | out       | tdata: row_index, rot_c0..2, str_c0..2, status ; tlast
//  cfg_    | in        | index 0 tolerance, index 1 max_iterations
//
// Each Newton step uses the shared divide/square-root unit for three quotients
// and two square roots; a step that finds a zero determinant ends the iteration
// and goes straight to the stretch product.
// Each matrix yields three output words, one per row.
// Reset is synchronous, active low; one matrix is in flight at a time.
// s_tready is low until all three result words are taken; m_tready stalls output.
`timescale 1ns / 1ps
`default_nettype none
`include "polar_decompose_3x3_defines.svh"
module polar_decompose_3x3 (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [295:0] s_tdata,   // mode, a00..a22
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [199:0]      m_tdata,   // row_index, rot_c0..2, str_c0..2, status
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [23:0]  cfg_data
);
    import pd3_pkg::*;

    state_t      st_reg, st_next;
    logic [23:0] tol_reg;
    logic [6:0]  iter_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        mode_reg, mode_next;
    status_t     stat_reg, stat_next;
    logic [1:0]  row_reg, row_next;
    q_t f_reg [9];
    q_t m_reg [9];
    q_t c_reg [9];
    q_t e_reg [9];
    q_t s_reg [9];
    q_t m_nxt [9];
    q_t c_nxt [9];
    q_t e_nxt [9];
    q_t s_nxt [9];
    q_t mo_reg, mi_reg, mo_next, mi_next;
    q_t det_reg, det_next, t1_reg, t1_next, t2_reg, t2_next;
    q_t gm_reg, gm_next, g1_reg, g1_next, g2_reg, g2_next;
    logic [2:0]  lop;
    q_t la [3][3];
    q_t lb [3][3];
    q_t lr [3][3];
    q_t le [3][3];
    q_t nm [9];
    q_t ncol, nrow;
    logic        du_start, du_sqrt, du_done, du_go_reg, du_go_next;
    q_t du_num, du_res;
    logic signed [33:0] du_den;
    lane_ctl_t   ctl;
    logic [6:0]  lim;
    logic [2:0]  ri;
    q_t sym [3];
    logic signed [63:0] sm;

    assign ctl.start = s_tvalid && s_tready;
    assign ctl.busy  = (st_reg != S_IDLE);
    assign s_tready  = !ctl.busy;
    assign cfg_ready = !ctl.busy;
    assign lim = (iter_reg == 7'd0) ? 7'd1 : iter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 24'd17; iter_reg <= 7'd32;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TOL:  tol_reg <= cfg_data;
                REG_ITER: iter_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            pd3_lane u_lane (
                .aclk(aclk), .op(lop),
                .a0(la[g][0]), .a1(la[g][1]), .a2(la[g][2]),
                .b0(lb[g][0]), .b1(lb[g][1]), .b2(lb[g][2]),
                .k1(g1_reg), .k2(g2_reg),
                .r0(lr[g][0]), .r1(lr[g][1]), .r2(lr[g][2]),
                .e0(le[g][0]), .e1(le[g][1]), .e2(le[g][2])
            );
        end
    endgenerate

    pd3_merge u_merge (
        .aclk(aclk), .m00(nm[0]), .m01(nm[1]), .m02(nm[2]), .m10(nm[3]),
        .m11(nm[4]), .m12(nm[5]), .m20(nm[6]), .m21(nm[7]), .m22(nm[8]),
        .ncol(ncol), .nrow(nrow)
    );

    pd3_divsqrt u_ds (
        .aclk(aclk), .aresetn(aresetn), .start(du_start), .is_sqrt(du_sqrt),
        .num(du_num), .den(du_den), .done(du_done), .res(du_res)
    );

    // lane operands by state; stretch uses M row i against columns of F
    always_comb begin
        lop = 3'd7;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                la[i][j] = m_reg[3*i+j]; lb[i][j] = c_reg[3*i+j];
            end
        case (st_reg)
            S_CROSS: begin
                lop = 3'd0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) begin
                        la[i][j] = m_reg[3*((i+1)%3)+j];
                        lb[i][j] = m_reg[3*((i+2)%3)+j];
                    end
            end
            S_DET: begin
                lop = 3'd2;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) lb[i][j] = lr[i][j];
            end
            S_UPD: lop = 3'd1;
            S_STR: begin
                lop = 3'd2;
                for (int j = 0; j < 3; j++) begin
                    la[j][0] = m_reg[3*row_reg+0]; la[j][1] = m_reg[3*row_reg+1];
                    la[j][2] = m_reg[3*row_reg+2];
                    lb[j][0] = f_reg[j]; lb[j][1] = f_reg[3+j]; lb[j][2] = f_reg[6+j];
                end
            end
            default: ;
        endcase
        for (int k = 0; k < 9; k++) nm[k] = m_reg[k];
        case (st_reg)
            S_CNORM, S_RMUL: for (int k = 0; k < 9; k++) nm[k] = c_reg[k];
            S_ENORM: for (int k = 0; k < 9; k++) nm[k] = le[k/3][k%3];
            default: ;
        endcase
    end

    always_comb begin
        st_next = st_reg; cnt_next = cnt_reg; mode_next = mode_reg;
        stat_next = stat_reg; row_next = row_reg;
        mo_next = mo_reg; mi_next = mi_reg; det_next = det_reg;
        t1_next = t1_reg; t2_next = t2_reg; gm_next = gm_reg;
        g1_next = g1_reg; g2_next = g2_reg; du_go_next = 1'b0;
        du_start = du_go_reg; du_sqrt = 1'b0; du_num = t1_reg; du_den = 34'(t2_reg);
        for (int k = 0; k < 9; k++) begin
            m_nxt[k] = m_reg[k]; c_nxt[k] = c_reg[k];
            e_nxt[k] = e_reg[k]; s_nxt[k] = s_reg[k];
        end
        case (st_reg)
            S_IDLE: if (ctl.start) begin
                mode_next = s_tdata[0]; cnt_next = 7'd0; st_next = S_NORM0;
            end
            S_NORM0: st_next = S_CROSS;
            S_CROSS: begin
                if (cnt_reg == 7'd0) begin mo_next = ncol; mi_next = nrow; end
                st_next = S_DET;
            end
            S_DET: begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) c_nxt[3*i+j] = lr[i][j];
                st_next = S_CNORM;
            end
            S_CNORM: begin
                det_next = lr[0][0];
                if (lr[0][0] == 0) begin
                    stat_next = ST_ZDET; row_next = 2'd0; st_next = S_STR;
                end else st_next = S_RMUL;
            end
            S_RMUL: begin
                t1_next = qmul(ncol, nrow); t2_next = qmul(mo_reg, mi_reg);
                du_go_next = 1'b1; st_next = S_DIV1;
            end
            S_DIV1: begin
                du_sqrt = 1'b0;
                if (du_done) begin t1_next = du_res; du_go_next = 1'b1; st_next = S_SQ1; end
            end
            S_SQ1: begin
                du_sqrt = 1'b1;
                if (du_done) begin
                    t1_next = du_res;
                    du_go_next = 1'b1; st_next = S_DIV2;
                end
            end
            S_DIV2: begin
                du_sqrt = 1'b0; du_den = qabs(det_reg);
                if (du_done) begin t1_next = du_res; du_go_next = 1'b1; st_next = S_SQ2; end
            end
            S_SQ2: begin
                du_sqrt = 1'b1;
                if (du_done) begin gm_next = du_res; st_next = S_G1; end
            end
            S_G1: begin
                g1_next = qmul(gm_reg, QHALF); t2_next = qmul(gm_reg, det_reg);
                t1_next = QHALF; du_go_next = 1'b1; st_next = S_DIV3;
            end
            S_DIV3: begin
                du_sqrt = 1'b0;
                if (du_done) begin g2_next = du_res; st_next = S_UPD; end
            end
            S_UPD: st_next = S_ENORM;
            S_ENORM: begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) begin
                        m_nxt[3*i+j] = lr[i][j]; e_nxt[3*i+j] = le[i][j];
                    end
                st_next = S_TOL;
            end
            S_TOL: begin
                t1_next = ncol; st_next = S_CHECK;
            end
            S_CHECK: begin
                mo_next = ncol; mi_next = nrow;
                row_next = 2'd0;
                if (t1_reg <= qmul(ncol, q_t'({8'd0, tol_reg}))) begin
                    stat_next = ST_CONV; st_next = S_STR;
                end else if (cnt_reg + 7'd1 >= lim) begin
                    stat_next = ST_LIMIT; st_next = S_STR;
                end else begin
                    cnt_next = cnt_reg + 7'd1; st_next = S_CROSS;
                end
            end
            S_STR: st_next = S_SYM;
            S_SYM: begin
                for (int j = 0; j < 3; j++) s_nxt[3*row_reg+j] = lr[j][0];
                if (row_reg == 2'd2) begin row_next = 2'd0; st_next = S_OUT; end
                else begin row_next = row_reg + 2'd1; st_next = S_STR; end
            end
            S_OUT: if (m_tready) begin
                if (row_reg == 2'd2) st_next = S_IDLE;
                else row_next = row_reg + 2'd1;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE; du_go_reg <= 1'b0;
        end else begin
            st_reg <= st_next; du_go_reg <= du_go_next;
        end
        cnt_reg <= cnt_next; mode_reg <= mode_next; stat_reg <= stat_next;
        row_reg <= row_next; mo_reg <= mo_next; mi_reg <= mi_next;
        det_reg <= det_next; t1_reg <= t1_next; t2_reg <= t2_next;
        gm_reg <= gm_next; g1_reg <= g1_next; g2_reg <= g2_next;
        for (int k = 0; k < 9; k++) begin
            if (st_reg == S_IDLE && ctl.start) begin
                f_reg[k] <= s_tdata[1+32*k +: 32];
                m_reg[k] <= s_tdata[1+32*(3*(k%3)+k/3) +: 32];
            end else m_reg[k] <= m_nxt[k];
            c_reg[k] <= c_nxt[k]; e_reg[k] <= e_nxt[k]; s_reg[k] <= s_nxt[k];
        end
    end

    always_comb begin
        ri = {1'b0, row_reg};
        for (int j = 0; j < 3; j++) begin
            sm = 64'(s_reg[3*ri+j]) + 64'(s_reg[3*j+ri]) + 64'sd1;
            sym[j] = mode_reg ? q_t'(sm >>> 1) : q_t'(0);
        end
        m_tvalid = (st_reg == S_OUT);
        m_tlast  = (row_reg == 2'd2);
        m_tdata  = {4'd0, stat_reg, sym[2], sym[1], sym[0],
                    m_reg[6+ri], m_reg[3+ri], m_reg[ri], row_reg};
    end

    `PD_ASSERT_IMPL(a_out_last, aclk, aresetn, m_tvalid && m_tlast, m_tdata[1:0] == 2'd2)
    `PD_ASSERT_IMPL(a_no_take, aclk, aresetn, m_tvalid, !s_tready)
    `PD_ASSERT_NEXT(a_done_once, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid)
endmodule
`default_nettype wire
